### hdl/ghw_pkg.sv
// ----------------------------------------------------------------------------
// ghw_pkg
// Shared types, constants and the Hann weight table of the grain windower.
// ----------------------------------------------------------------------------
package ghw_pkg;

  localparam int MAX_GRAIN       = 4096;
  localparam int SAMPLE_BITS     = 16;
  localparam int COS_TABLE_DEPTH = 1024;
  localparam int CTAB_AW         = $clog2(COS_TABLE_DEPTH);
  localparam int LEN_W           = 13;
  localparam int IDX_W           = 12;
  localparam int WORD_W          = 16;
  localparam int DIVD_W          = 33;
  localparam int DIVS_W          = 16;
  localparam int CNT_W           = 6;
  localparam logic [WORD_W:0] Q15_ONE = 17'd32768;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          first;
    logic [LEN_W-1:0]              len;
    logic [WORD_W-1:0]             expected;
    logic [WORD_W-1:0]             start;
  } item_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_STEP,
    B_RATIO,
    B_WEIGHT,
    B_OUT
  } back_state_t;

  typedef logic [WORD_W:0] hann_lut_t [COS_TABLE_DEPTH];

  function automatic hann_lut_t build_hann();
    hann_lut_t  lut;
    longint unsigned m, y, y2, t, s, w, d;
    d = longint'(COS_TABLE_DEPTH);
    for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
      m  = (longint'(k) <= d - longint'(k)) ? longint'(k) : d - longint'(k);
      y  = (64'd3373259426 * m) / COS_TABLE_DEPTH;
      y2 = (y * y) >> 30;
      t  = 64'd1073741824;
      t  = 64'd1073741824 - ((y2 * t) >> 30) / 110;
      t  = 64'd1073741824 - ((y2 * t) >> 30) / 72;
      t  = 64'd1073741824 - ((y2 * t) >> 30) / 42;
      t  = 64'd1073741824 - ((y2 * t) >> 30) / 20;
      t  = 64'd1073741824 - ((y2 * t) >> 30) / 6;
      s  = (y * t) >> 30;
      if (s > 64'd1073741824) s = 64'd1073741824;
      w  = (s * s) >> 30;
      w  = (w + 64'd16384) >> 15;
      if (w > 64'd32768) w = 64'd32768;
      lut[k] = w[WORD_W:0];
    end
    return lut;
  endfunction

  localparam hann_lut_t HANN_LUT = build_hann();

endpackage

### hdl/grain_hann_windower_core.sv
// ----------------------------------------------------------------------------
// grain_hann_windower_core
// Hann windowing of pitch-synchronous grains, one sample per item.
// ----------------------------------------------------------------------------
// path: a continuing item goes from the weight and sample registers to the
//   output register; a first item first waits for two 33-bit divisions
//   (step, then size ratio); the next item is taken once the last is output
// reset: synchronous active-low rst_n clears the queue, the output valid flag
//   and the grain state (length one, expected length one, position zero)
module grain_hann_windower_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [ghw_pkg::SAMPLE_BITS-1:0] in_sample_in,
  input  logic                               in_first_of_grain,
  input  logic [ghw_pkg::LEN_W-1:0]          in_grain_length,
  input  logic [ghw_pkg::WORD_W-1:0]         in_expected_length,
  input  logic [ghw_pkg::WORD_W-1:0]         in_grain_start,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [ghw_pkg::SAMPLE_BITS-1:0] out_windowed_sample,
  output logic [ghw_pkg::IDX_W-1:0]          out_position,
  output logic                               out_last_of_grain,
  output logic [ghw_pkg::WORD_W-1:0]         out_size_ratio,
  output logic [ghw_pkg::WORD_W-1:0]         out_pitch_mark
);
  import ghw_pkg::*;

  logic     q_valid, q_pop;
  item_t    q_head;
  div_req_t div_req;
  div_rsp_t div_rsp;

  ghw_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample_in       (in_sample_in),
    .in_first_of_grain  (in_first_of_grain),
    .in_grain_length    (in_grain_length),
    .in_expected_length (in_expected_length),
    .in_grain_start     (in_grain_start),
    .q_valid            (q_valid),
    .q_pop              (q_pop),
    .q_head             (q_head)
  );

  ghw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  ghw_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_pop               (q_pop),
    .q_head              (q_head),
    .div_req             (div_req),
    .div_rsp             (div_rsp),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_windowed_sample (out_windowed_sample),
    .out_position        (out_position),
    .out_last_of_grain   (out_last_of_grain),
    .out_size_ratio      (out_size_ratio),
    .out_pitch_mark      (out_pitch_mark)
  );

endmodule

### hdl/ghw_front.sv
// ----------------------------------------------------------------------------
// ghw_front
// Accepts items, clamps the grain length and queues them for the back end.
// ----------------------------------------------------------------------------
module ghw_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [ghw_pkg::SAMPLE_BITS-1:0] in_sample_in,
  input  logic                           in_first_of_grain,
  input  logic [ghw_pkg::LEN_W-1:0]      in_grain_length,
  input  logic [ghw_pkg::WORD_W-1:0]     in_expected_length,
  input  logic [ghw_pkg::WORD_W-1:0]     in_grain_start,
  output logic                           q_valid,
  input  logic                           q_pop,
  output ghw_pkg::item_t                 q_head
);
  import ghw_pkg::*;

  item_t      slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  item_t      item;
  logic       push, pop;

  always_comb begin
    item.sample   = in_sample_in;
    item.first    = in_first_of_grain;
    item.expected = in_expected_length;
    item.start    = in_grain_start;
    if (in_grain_length == '0) begin
      item.len = LEN_W'(1);
    end else if (in_grain_length > LEN_W'(MAX_GRAIN)) begin
      item.len = LEN_W'(MAX_GRAIN);
    end else begin
      item.len = in_grain_length;
    end
  end

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_head   = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item;
    end
  end

endmodule

### hdl/ghw_div.sv
// ----------------------------------------------------------------------------
// ghw_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ghw_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ghw_pkg::div_req_t req,
  output ghw_pkg::div_rsp_t rsp
);
  import ghw_pkg::*;

  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVS_W-1:0] rem_r, rem_nxt, dsr_r, dsr_nxt;
  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [DIVS_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    trial    = {rem_r, quo_r[DIVD_W-1]};
    if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = DIVS_W'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[DIVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIVS_W-1:0];
        quo_nxt = {quo_r[DIVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIVD_W - 1);
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      quo_nxt  = req.dividend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

### hdl/ghw_back.sv
// ----------------------------------------------------------------------------
// ghw_back
// Latches grain setup, runs the per-grain divisions and windows each sample.
// ----------------------------------------------------------------------------
module ghw_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  ghw_pkg::item_t             q_head,
  output ghw_pkg::div_req_t          div_req,
  input  ghw_pkg::div_rsp_t          div_rsp,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [ghw_pkg::SAMPLE_BITS-1:0] out_windowed_sample,
  output logic [ghw_pkg::IDX_W-1:0]  out_position,
  output logic                       out_last_of_grain,
  output logic [ghw_pkg::WORD_W-1:0] out_size_ratio,
  output logic [ghw_pkg::WORD_W-1:0] out_pitch_mark
);
  import ghw_pkg::*;

  localparam logic [31:0] HALF_BIN = 32'(64'd1 << (31 - CTAB_AW));

  back_state_t state_r, state_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [WORD_W-1:0] exp_r, exp_nxt, start_r, start_nxt, ratio_r, ratio_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [31:0]       step_r, step_nxt, acc_r, acc_nxt, rnd;
  logic signed [SAMPLE_BITS-1:0] smp_r, smp_nxt;
  logic [WORD_W:0]   weight_r, weight_nxt, weight_now;
  logic              ov_r, ov_nxt, last;
  logic signed [SAMPLE_BITS-1:0] ows_r, ows_nxt;
  logic [IDX_W-1:0]  opos_r, opos_nxt;
  logic              olast_r, olast_nxt;
  logic [WORD_W-1:0] oratio_r, oratio_nxt, omark_r, omark_nxt;
  logic [LEN_W-1:0]  dm1;
  logic signed [SAMPLE_BITS+WORD_W:0] prod;
  logic signed [SAMPLE_BITS+2:0]      res;

  assign rnd  = acc_r + HALF_BIN;
  assign dm1  = len_r - LEN_W'(1);
  assign last = ({1'b0, idx_r} >= dm1);

  always_comb begin
    if (len_r == LEN_W'(1)) begin
      weight_now = Q15_ONE;
    end else begin
      weight_now = HANN_LUT[rnd[31 -: CTAB_AW]];
    end
    prod = smp_r * $signed({1'b0, weight_r});
    res  = (SAMPLE_BITS+3)'((prod + (SAMPLE_BITS+WORD_W+1)'(16384)) >>> 15);
  end

  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    exp_nxt    = exp_r;
    start_nxt  = start_r;
    ratio_nxt  = ratio_r;
    idx_nxt    = idx_r;
    step_nxt   = step_r;
    acc_nxt    = acc_r;
    smp_nxt    = smp_r;
    weight_nxt = weight_r;
    ov_nxt     = ov_r && !out_ready;
    ows_nxt    = ows_r;
    opos_nxt   = opos_r;
    olast_nxt  = olast_r;
    oratio_nxt = oratio_r;
    omark_nxt  = omark_r;
    q_pop      = 1'b0;
    div_req    = '0;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          smp_nxt = q_head.sample;
          if (q_head.first) begin
            len_nxt   = q_head.len;
            exp_nxt   = q_head.expected;
            start_nxt = q_head.start;
            idx_nxt   = '0;
            acc_nxt   = '0;
            div_req.start    = 1'b1;
            div_req.dividend = {1'b1, 32'd0} + DIVD_W'(q_head.len - LEN_W'(1) >> 1);
            div_req.divisor  = (q_head.len == LEN_W'(1)) ? DIVS_W'(1)
                                                         : DIVS_W'(q_head.len - LEN_W'(1));
            state_nxt = B_STEP;
          end else begin
            weight_nxt = weight_now;
            state_nxt  = B_OUT;
          end
        end
      end
      B_STEP: begin
        if (div_rsp.done) begin
          step_nxt = (len_r == LEN_W'(1)) ? 32'd0 : div_rsp.quotient[31:0];
          div_req.start    = 1'b1;
          div_req.dividend = DIVD_W'({len_r, 8'd0});
          div_req.divisor  = (exp_r == '0) ? DIVS_W'(1) : exp_r;
          state_nxt = B_RATIO;
        end
      end
      B_RATIO: begin
        if (div_rsp.done) begin
          if (exp_r == '0 || div_rsp.quotient > DIVD_W'(16'hFFFF)) begin
            ratio_nxt = 16'hFFFF;
          end else begin
            ratio_nxt = div_rsp.quotient[WORD_W-1:0];
          end
          state_nxt = B_WEIGHT;
        end
      end
      B_WEIGHT: begin
        weight_nxt = weight_now;
        state_nxt  = B_OUT;
      end
      B_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt   = 1'b1;
          opos_nxt = idx_r;
          olast_nxt = last;
          oratio_nxt = last ? ratio_r : '0;
          omark_nxt = start_r;
          if (res > (SAMPLE_BITS+3)'(32767)) begin
            ows_nxt = 16'sh7FFF;
          end else if (res < -(SAMPLE_BITS+3)'(32768)) begin
            ows_nxt = 16'sh8000;
          end else begin
            ows_nxt = res[SAMPLE_BITS-1:0];
          end
          if (last) begin
            idx_nxt = '0;
            acc_nxt = '0;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
            acc_nxt = acc_r + step_r;
          end
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      len_r   <= LEN_W'(1);
      exp_r   <= WORD_W'(1);
      start_r <= '0;
      ratio_r <= WORD_W'(256);
      idx_r   <= '0;
      step_r  <= '0;
      acc_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      exp_r   <= exp_nxt;
      start_r <= start_nxt;
      ratio_r <= ratio_nxt;
      idx_r   <= idx_nxt;
      step_r  <= step_nxt;
      acc_r   <= acc_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    smp_r    <= smp_nxt;
    weight_r <= weight_nxt;
    ows_r    <= ows_nxt;
    opos_r   <= opos_nxt;
    olast_r  <= olast_nxt;
    oratio_r <= oratio_nxt;
    omark_r  <= omark_nxt;
  end

  assign out_valid           = ov_r;
  assign out_windowed_sample = ows_r;
  assign out_position        = opos_r;
  assign out_last_of_grain   = olast_r;
  assign out_size_ratio      = oratio_r;
  assign out_pitch_mark      = omark_r;

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_OUT |-> weight_r <= Q15_ONE)
    else $error("weight above unity");

  a_wrap_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_OUT && (!ov_r || out_ready) && last) |=> (idx_r == '0 && acc_r == '0))
    else $error("grain did not wrap after last item");

  a_ratio_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_last_of_grain) |-> out_size_ratio == '0)
    else $error("ratio reported on a non-final item");

endmodule

### tb/sv/grain_hann_windower_core_tb.sv
// ----------------------------------------------------------------------------
// grain_hann_windower_core_tb
// Self-checking bench: directed and random grains are pushed through the
// windower under several idle and stall patterns, and every windowed item is
// compared field by field against an in-bench Hann windowing predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

typedef struct {
  logic signed [15:0] windowed;
  logic [11:0]        position;
  logic               last;
  logic [15:0]        ratio;
  logic [15:0]        mark;
} win_result_t;

class grain_scoreboard;
  int unsigned grain_idx;
  int unsigned grain_len;
  int unsigned turn_step;
  int unsigned turn_phase;
  int unsigned exp_len;
  int unsigned mark_pos;
  win_result_t pending_q[$];
  int errors;

  function void clear();
    grain_idx  = 0;
    grain_len  = 0;
    turn_step  = 0;
    turn_phase = 0;
    exp_len    = 1;
    mark_pos   = 0;
    errors     = 0;
    pending_q.delete();
  endfunction

  // sin^2 of the table angle, q1.15
  function int unsigned hann_weight(int unsigned phase);
    longint unsigned k, m, y, y2, t, s, w;
    longint unsigned one;
    one = 64'd1073741824;
    k = ((longint'(phase) * ghw_pkg::COS_TABLE_DEPTH) + 64'd2147483648) >> 32;
    if (k >= ghw_pkg::COS_TABLE_DEPTH) k -= ghw_pkg::COS_TABLE_DEPTH;
    m = (k <= ghw_pkg::COS_TABLE_DEPTH - k) ? k : ghw_pkg::COS_TABLE_DEPTH - k;
    y = (64'd3373259426 * m) / ghw_pkg::COS_TABLE_DEPTH;
    y2 = (y * y) >> 30;
    t = one;
    t = one - ((y2 * t) >> 30) / 110;
    t = one - ((y2 * t) >> 30) / 72;
    t = one - ((y2 * t) >> 30) / 42;
    t = one - ((y2 * t) >> 30) / 20;
    t = one - ((y2 * t) >> 30) / 6;
    s = (y * t) >> 30;
    if (s > one) s = one;
    w = (s * s) >> 30;
    w = (w + 64'd16384) >> 15;
    if (w > 64'd32768) w = 64'd32768;
    return int'(w);
  endfunction

  function void note_item(logic signed [15:0] sample, logic first, logic [12:0] len,
                          logic [15:0] expected, logic [15:0] start);
    int unsigned n, wt;
    longint prod, res;
    win_result_t r;
    if (first) begin
      n = len;
      if (n == 0) n = 1;
      if (n > ghw_pkg::MAX_GRAIN) n = ghw_pkg::MAX_GRAIN;
      grain_len  = n;
      exp_len    = expected;
      mark_pos   = start;
      grain_idx  = 0;
      turn_phase = 0;
      turn_step  = (n > 1) ? int'((64'd4294967296 + (n - 1) / 2) / (n - 1)) : 0;
    end
    n  = (grain_len == 0) ? 1 : grain_len;
    wt = (n == 1) ? 32768 : hann_weight(turn_phase);
    prod = longint'(sample) * longint'(wt);
    res  = (prod + 16384) >>> 15;
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    r.windowed = res[15:0];
    r.position = grain_idx[11:0];
    r.last     = (grain_idx >= n - 1);
    r.ratio    = 0;
    r.mark     = mark_pos[15:0];
    if (r.last) begin
      if (exp_len == 0) r.ratio = 16'hffff;
      else if ((longint'(n) * 256) / exp_len > 65535) r.ratio = 16'hffff;
      else r.ratio = 16'((longint'(n) * 256) / exp_len);
      grain_idx  = 0;
      turn_phase = 0;
    end else begin
      grain_idx  = grain_idx + 1;
      turn_phase = turn_phase + turn_step;
    end
    pending_q.push_back(r);
  endfunction

  function void check_result(win_result_t got);
    win_result_t want;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected item ws=%0d pos=%0d", $time, got.windowed, got.position);
      errors++;
      return;
    end
    want = pending_q.pop_front();
    if (got.windowed !== want.windowed) begin
      $display("%0t: windowed_sample exp %0d got %0d", $time, want.windowed, got.windowed);
      errors++;
    end
    if (got.position !== want.position) begin
      $display("%0t: position exp %0d got %0d", $time, want.position, got.position);
      errors++;
    end
    if (got.last !== want.last) begin
      $display("%0t: last_of_grain exp %0d got %0d", $time, want.last, got.last);
      errors++;
    end
    if (got.ratio !== want.ratio) begin
      $display("%0t: size_ratio exp %0d got %0d", $time, want.ratio, got.ratio);
      errors++;
    end
    if (got.mark !== want.mark) begin
      $display("%0t: pitch_mark exp %0d got %0d", $time, want.mark, got.mark);
      errors++;
    end
  endfunction
endclass

module grain_hann_windower_core_tb;
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_sample_in = '0;
  logic               in_first_of_grain = 1'b0;
  logic [12:0]        in_grain_length = '0;
  logic [15:0]        in_expected_length = '0;
  logic [15:0]        in_grain_start = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_windowed_sample;
  logic [11:0]        out_position;
  logic               out_last_of_grain;
  logic [15:0]        out_size_ratio;
  logic [15:0]        out_pitch_mark;

  grain_scoreboard windows_sb;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     hold_left = 0;
  longint unsigned cycle_count = 0;

  grain_hann_windower_core u_top (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 64'd1000000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    win_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.windowed = out_windowed_sample;
      got.position = out_position;
      got.last     = out_last_of_grain;
      got.ratio    = out_size_ratio;
      got.mark     = out_pitch_mark;
      windows_sb.check_result(got);
    end
  end

  task automatic send_item(logic signed [15:0] sample, logic first, logic [12:0] len,
                           logic [15:0] expected, logic [15:0] start);
    in_sample_in       <= sample;
    in_first_of_grain  <= first;
    in_grain_length    <= len;
    in_expected_length <= expected;
    in_grain_start     <= start;
    in_valid           <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    windows_sb.note_item(sample, first, len, expected, start);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // grain header then count-1 continuing items with junk in the ignored fields
  task automatic send_grain(logic [12:0] len, logic [15:0] expected, logic [15:0] start,
                            int count);
    send_item(16'($urandom), 1'b1, len, expected, start);
    for (int i = 1; i < count; i++)
      send_item(16'($urandom), 1'b0, 13'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (windows_sb.pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_grains(int items);
    int sent, n, cnt, sel;
    sent = 0;
    while (sent < items) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        send_item(16'($urandom), 1'b0, 13'($urandom), 16'($urandom), 16'($urandom));
        sent++;
      end else begin
        n = (sel < 14) ? $urandom_range(8191) : $urandom_range(24, 1);
        cnt = (n == 0) ? 1 : (n > 4096 ? 4096 : n);
        if (cnt > 30) cnt = $urandom_range(30, 1);
        else if (sel < 22) cnt = $urandom_range(cnt + 4, 1);
        send_grain(13'(n), ($urandom_range(9) == 0) ? 16'($urandom) :
                   16'($urandom_range(40)), 16'($urandom), cnt);
        sent += cnt;
      end
    end
  endtask

  initial begin
    windows_sb = new();
    windows_sb.clear();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // items before any grain, then the edge cases
    send_item(16'sh7fff, 1'b0, 13'h1fff, 16'hffff, 16'hffff);
    send_item(-16'sd32768, 1'b0, 13'h0, 16'h0, 16'h0);
    send_grain(13'd0, 16'd1, 16'hffff, 1);
    send_item(-16'sd32768, 1'b1, 13'd1, 16'd0, 16'h0);
    send_item(16'sh7fff, 1'b1, 13'd2, 16'd1, 16'h5a5a);
    send_item(-16'sd32768, 1'b0, 13'd0, 16'd0, 16'd0);
    send_grain(13'd3, 16'd0, 16'ha5a5, 3);
    send_grain(13'd5, 16'hffff, 16'hffff, 8);
    send_grain(13'h1fff, 16'd1, 16'd0, 4);
    send_grain(13'd4096, 16'd4096, 16'h1234, 3);
    drain();

    send_idle_pct = 0;  recv_stall_pct = 0;  random_grains(150);
    send_idle_pct = 74; recv_stall_pct = 0;  random_grains(110);
    send_idle_pct = 0;  recv_stall_pct = 74; random_grains(110);
    drain();
    hold_left = 400;
    send_idle_pct = 0;  recv_stall_pct = 0;
    send_grain(13'd60, 16'd1, 16'h0f0f, 60);
    send_idle_pct = 20; recv_stall_pct = 20; random_grains(140);

    drain();
    if (windows_sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
